@@ hdl/swhsr_pkg.sv @@
// Shared types and constants for the single-wire humidity sensor reader.
`default_nettype none

package swhsr_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FRAME_W    = 64;

	typedef logic [TIMER_BITS-1:0] tstamp_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [FRAME_W-1:0]    frame_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_EDGE  = 2'd2
	} cmd_t;

	localparam cfg_idx_t REG_WAKE_LOW = 3'd0;
	localparam cfg_idx_t REG_SETTLE   = 3'd1;
	localparam cfg_idx_t REG_ZERO_MIN = 3'd2;
	localparam cfg_idx_t REG_ZERO_MAX = 3'd3;
	localparam cfg_idx_t REG_ONE_MIN  = 3'd4;
	localparam cfg_idx_t REG_ONE_MAX  = 3'd5;

	typedef struct packed {
		logic [7:0]  wake_low_ms;
		logic [7:0]  settle_ms;
		logic [15:0] zero_min_us;
		logic [15:0] zero_max_us;
		logic [15:0] one_min_us;
		logic [15:0] one_max_us;
	} cfg_t;

	// Low byte of the sum of bytes 4..1 must match byte 0.
	function automatic logic frame_checks(frame_t f);
		logic [7:0] s;
		s = f[39:32] + f[31:24] + f[23:16] + f[15:8];
		return s == f[7:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/swhsr_cfg.sv @@
// Configuration register file for the single-wire humidity sensor reader.
`default_nettype none

module swhsr_cfg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire swhsr_pkg::cfg_idx_t  cfg_idx,
	input  wire swhsr_pkg::cfg_data_t cfg_wdata,
	output swhsr_pkg::cfg_t           cfg
);

	swhsr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_low_ms <= 8'd40;
			cfg_q.settle_ms   <= 8'd6;
			cfg_q.zero_min_us <= 16'd15;
			cfg_q.zero_max_us <= 16'd30;
			cfg_q.one_min_us  <= 16'd40;
			cfg_q.one_max_us  <= 16'd74;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				swhsr_pkg::REG_WAKE_LOW: cfg_q.wake_low_ms <= cfg_wdata[7:0];
				swhsr_pkg::REG_SETTLE:   cfg_q.settle_ms   <= cfg_wdata[7:0];
				swhsr_pkg::REG_ZERO_MIN: cfg_q.zero_min_us <= cfg_wdata;
				swhsr_pkg::REG_ZERO_MAX: cfg_q.zero_max_us <= cfg_wdata;
				swhsr_pkg::REG_ONE_MIN:  cfg_q.one_min_us  <= cfg_wdata;
				swhsr_pkg::REG_ONE_MAX:  cfg_q.one_max_us  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/single_wire_humidity_sensor_reader.sv @@
// Top level of the single-wire humidity sensor reader.
// Every input beat (start, millisecond tick or line edge) yields exactly one result beat
// carrying the status after that event; on the tick that closes the receive window the
// result also carries the 64-bit frame if its checksum matches, else zero. One beat per
// clock is sustained while out_ready is high: the beat is captured in an input
// register, the phase/timing/shift update runs as compares and a shift, and the result
// lands in an output register. While a result waits the input register takes one more
// beat, then in_ready stays low until the waiting result is taken.
`default_nettype none

module single_wire_humidity_sensor_reader (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           cmd,
	input  wire logic [15:0]          timestamp_us,
	input  wire logic                 line_level,
	input  wire logic                 cfg_we,
	input  wire swhsr_pkg::cfg_idx_t  cfg_idx,
	input  wire swhsr_pkg::cfg_data_t cfg_wdata,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      line_drive_low,
	output logic                      busy_res,
	output logic                      done_res,
	output logic                      checksum_ok,
	output logic [63:0]               frame
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAKE = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	swhsr_pkg::cfg_t cfg;

	swhsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	logic              valid_s1;
	logic [1:0]        cmd_s1;
	swhsr_pkg::tstamp_t ts_s1;
	logic              level_s1;

	// state
	phase_t             phase_q;
	logic [7:0]         ms_q;
	swhsr_pkg::tstamp_t last_q;
	swhsr_pkg::frame_t  shift_q;

	// result register
	logic              out_valid_q;
	logic              drive_q;
	logic              busy_q;
	logic              done_q;
	logic              ok_q;
	swhsr_pkg::frame_t frame_q;

	logic adv;
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= cmd;
			ts_s1    <= timestamp_us[swhsr_pkg::TIMER_BITS-1:0];
			level_s1 <= line_level;
		end
	end

	// next-state logic
	phase_t             phase_d;
	logic [7:0]         ms_d;
	swhsr_pkg::tstamp_t last_d;
	swhsr_pkg::frame_t  shift_d;
	logic               done_d;
	logic               ok_d;
	swhsr_pkg::frame_t  frame_d;
	logic [8:0]         ms_next;
	swhsr_pkg::tstamp_t pulse_w;
	logic               in_zero;
	logic               in_one;
	swhsr_pkg::frame_t  shift_z;

	always_comb begin
		phase_d = phase_q;
		ms_d    = ms_q;
		last_d  = last_q;
		shift_d = shift_q;
		done_d  = 1'b0;
		ok_d    = 1'b0;
		frame_d = '0;
		ms_next = {1'b0, ms_q} + 9'd1;
		pulse_w = ts_s1 - last_q;
		in_zero = (32'(pulse_w) > 32'(cfg.zero_min_us)) &&
		          (32'(pulse_w) < 32'(cfg.zero_max_us));
		in_one  = (32'(pulse_w) > 32'(cfg.one_min_us)) &&
		          (32'(pulse_w) < 32'(cfg.one_max_us));
		shift_z = in_zero ? {shift_q[62:0], 1'b0} : shift_q;

		case (cmd_s1)
			swhsr_pkg::CMD_START: begin
				shift_d = '0;
				last_d  = ts_s1;
				ms_d    = '0;
				phase_d = (cfg.wake_low_ms == 8'd0) ? PH_DATA : PH_WAKE;
			end
			swhsr_pkg::CMD_TICK: begin
				if (phase_q == PH_WAKE) begin
					if (ms_next >= {1'b0, cfg.wake_low_ms}) begin
						phase_d = PH_DATA;
						ms_d    = '0;
					end else begin
						ms_d = ms_next[7:0];
					end
				end else if (phase_q == PH_DATA) begin
					if (ms_next > {1'b0, cfg.settle_ms}) begin
						done_d  = 1'b1;
						ok_d    = swhsr_pkg::frame_checks(shift_q);
						frame_d = ok_d ? shift_q : '0;
						phase_d = PH_IDLE;
						ms_d    = '0;
					end else begin
						ms_d = ms_next[7:0];
					end
				end
			end
			swhsr_pkg::CMD_EDGE: begin
				last_d = ts_s1;
				// widths inside both windows shift in a 0 and then a 1
				if (!level_s1) begin
					shift_d = in_one ? {shift_z[62:0], 1'b1} : shift_z;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			ms_q        <= '0;
			last_q      <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q     <= phase_d;
				ms_q        <= ms_d;
				last_q      <= last_d;
				shift_q     <= shift_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= (phase_d == PH_WAKE);
			busy_q  <= (phase_d != PH_IDLE);
			done_q  <= done_d;
			ok_q    <= ok_d;
			frame_q <= frame_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign line_drive_low = drive_q;
	assign busy_res       = busy_q;
	assign done_res       = done_q;
	assign checksum_ok    = ok_q;
	assign frame          = frame_q;

endmodule

`default_nettype wire

@@ hdl/swhsr_chk.sv @@
// Port-level checker for the single-wire humidity sensor reader, with its bind.
`default_nettype none

module swhsr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        line_drive_low,
	input wire logic        busy_res,
	input wire logic        done_res,
	input wire logic        checksum_ok,
	input wire logic [63:0] frame
);

	// wake phase is always part of a busy read
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_drive_low |-> busy_res)
		else $error("line driven low outside a read");

	// the closing beat returns the block to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !line_drive_low)
		else $error("done beat while still busy");

	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_ok |-> done_res)
		else $error("checksum flag without done");

	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame != 64'd0) |-> checksum_ok)
		else $error("nonzero frame without good checksum");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame) && $stable(done_res))
		else $error("stalled result beat changed");

endmodule

bind single_wire_humidity_sensor_reader swhsr_chk u_swhsr_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.line_drive_low (line_drive_low),
	.busy_res       (busy_res),
	.done_res       (done_res),
	.checksum_ok    (checksum_ok),
	.frame          (frame)
);

`default_nettype wire
